### sv/rgb_gaussian_blur_edge_normalized_macros.svh
// ---------------------------------------------------------------------------
// rgb_gaussian_blur_edge_normalized_macros.svh
// Assertion macros for the RGB Gaussian blur block.
// ---------------------------------------------------------------------------
`ifndef RGB_GAUSSIAN_BLUR_EDGE_NORMALIZED_MACROS_SVH
`define RGB_GAUSSIAN_BLUR_EDGE_NORMALIZED_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on i_clk, off during reset
`define RGBG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RGBG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RGBG_ASSERT_IMP(lbl, ante, cons, msg)
`define RGBG_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### sv/rgbg_pkg.sv
// ---------------------------------------------------------------------------
// rgbg_pkg
// Types and constants shared by the RGB Gaussian blur modules.
// ---------------------------------------------------------------------------
package rgbg_pkg;

    localparam int PIX_W     = 8;
    localparam int N_CH      = 3;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int WGT_W     = 8;
    localparam int ROW_CNT_W = 12;
    localparam int COL_CNT_W = 11;
    localparam int POS_OUT_W = 11;
    localparam int CW_W      = 2 * WGT_W;
    localparam int PROD_W    = CW_W + PIX_W;
    // sums sized for the largest window (7 x 7)
    localparam int ACC_W     = 30;
    localparam int DSUM_W    = 22;
    localparam int NUM_W     = ACC_W + 1;
    localparam int DD_W      = DSUM_W + 1;
    localparam int QUO_W     = PIX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WGT_CENTER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WGT_ONE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WGT_TWO      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WGT_THREE    = 3'd5;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;
    localparam logic [WGT_W-1:0] RST_WGT0   = 8'd255;
    localparam logic [WGT_W-1:0] RST_WGT1   = 8'd204;
    localparam logic [WGT_W-1:0] RST_WGT2   = 8'd105;
    localparam logic [WGT_W-1:0] RST_WGT3   = 8'd35;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0]     out_red;
        logic [PIX_W-1:0]     out_green;
        logic [PIX_W-1:0]     out_blue;
        logic [POS_OUT_W-1:0] out_row;
        logic [POS_OUT_W-1:0] out_col;
        logic                 frame_done;
    } t_out;

    // one stage of the divider chain: partial remainders and quotients
    typedef struct packed {
        logic [N_CH-1:0][NUM_W-1:0] rem;
        logic [DD_W-1:0]            dd;
        logic [N_CH-1:0][QUO_W-1:0] quo;
        logic                       zero;
        logic [POS_OUT_W-1:0]       row;
        logic [POS_OUT_W-1:0]       col;
        logic                       done;
    } t_div_data;

endpackage

### sv/rgb_gaussian_blur_edge_normalized.sv
// Per item: a drain item inside the frame passes S_POS and S_CHK and is dropped;
//   any other item also waits in S_MOD for the bit-serial position divider.
// An item that yields a pixel adds (2*RADIUS+1)^2 row-store reads (one per cycle
//   on the RAM read port), then the multiply, sum and divider chain.
// Throughput: one item at a time; the next item is taken once the result sits in
//   the output register. Reset is synchronous active low, clears control and config only.
// ---------------------------------------------------------------------------
// rgb_gaussian_blur_edge_normalized
// Edge-normalized separable Gaussian blur over an RGB raster stream.
// ---------------------------------------------------------------------------
`include "rgb_gaussian_blur_edge_normalized_macros.svh"

module rgb_gaussian_blur_edge_normalized #(
    parameter int RADIUS     = 3,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgbg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rgbg_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    input  rgbg_pkg::t_in                       i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output rgbg_pkg::t_out                      o_out_data,
    input  logic                                i_out_stall
);

    localparam int SPAN  = 2 * RADIUS + 1;
    localparam int DEPTH = SPAN * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int MD_W  = $clog2(DEPTH + 1);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int P_W   = $clog2(4096 * MAX_WIDTH + MAX_WIDTH * MAX_HEIGHT + 8 * MAX_WIDTH);
    localparam int RC_W  = $clog2(MAX_WIDTH + MAX_HEIGHT + 8) + 1;
    localparam int D_W   = $clog2(SPAN);
    localparam int PIX3  = 3 * rgbg_pkg::PIX_W;
    localparam int RECIP = (1 << P_W) / DEPTH;
    localparam int RQ_W  = $clog2(RECIP + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POS  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    // configuration
    logic [rgbg_pkg::CFG_W-1:0] r_cfg_width;
    logic [rgbg_pkg::CFG_W-1:0] r_cfg_height;
    logic [rgbg_pkg::WGT_W-1:0] r_wgt [4];
    logic [W_W-1:0]             w_eff;
    logic [H_W-1:0]             h_eff;

    // control
    logic [2:0]                      r_state;
    logic [rgbg_pkg::ROW_CNT_W-1:0]  r_row;
    logic [rgbg_pkg::COL_CNT_W-1:0]  r_col;
    logic                            r_real;
    logic [PIX3-1:0]                 r_pix;
    logic [P_W-1:0]                  r_p;
    logic [P_W-1:0]                  r_total;
    logic                            r_store;
    logic                            r_has_out;
    logic                            r_frame_done;

    logic                            in_acc;
    logic [P_W-1:0]                  off_c;
    logic [P_W-1:0]                  last_c;
    logic                            restart;
    logic [P_W-1:0]                  peff;
    logic                            store;
    logic                            has_out;
    logic [P_W-1:0]                  cp;
    logic                            go;
    logic [rgbg_pkg::ROW_CNT_W:0]    ncol;

    // position dividers
    logic                            div_start;
    logic [P_W+RQ_W-1:0]             mq_prod;
    logic [RQ_W-1:0]                 r_mq;
    logic [MD_W:0]                   r_mr;
    logic [MD_W-1:0]                 mod_rem;
    logic                            col_done;
    logic [P_W-1:0]                  col_quo;
    logic [W_W-1:0]                  col_rem;

    // window walk
    logic [AW-1:0]                   r_rdaddr;
    logic [D_W-1:0]                  r_dy;
    logic [D_W-1:0]                  r_dx;
    logic signed [RC_W-1:0]          r_rr;
    logic signed [RC_W-1:0]          r_cc0;
    logic signed [RC_W-1:0]          r_cc2;
    logic [rgbg_pkg::POS_OUT_W-1:0]  r_meta_row;
    logic [rgbg_pkg::POS_OUT_W-1:0]  r_meta_col;
    logic [MD_W-1:0]                 span_c;
    logic [MD_W:0]                   start_addr;
    logic [MD_W:0]                   step_a;
    logic [MD_W:0]                   jump_a;
    logic [MD_W:0]                   jump_b;
    logic [AW-1:0]                   next_addr;
    logic                            at_end;
    logic                            row_end;
    logic                            inb;
    logic [rgbg_pkg::WGT_W-1:0]      wy;
    logic [rgbg_pkg::WGT_W-1:0]      wx;

    // RAM
    logic                            ram_we;
    logic [PIX3-1:0]                 ram_rdata;

    // multiply-accumulate pipe
    logic                                           r_s1_valid;
    logic                                           r_s1_last;
    logic                                           r_s1_inb;
    logic [rgbg_pkg::CW_W-1:0]                      r_s1_cw;
    logic                                           r_s2_valid;
    logic                                           r_s2_last;
    logic [rgbg_pkg::CW_W-1:0]                      r_s2_d;
    logic [rgbg_pkg::N_CH-1:0][rgbg_pkg::PROD_W-1:0] r_s2_prod;
    logic [rgbg_pkg::N_CH-1:0][rgbg_pkg::ACC_W-1:0]  r_acc;
    logic [rgbg_pkg::DSUM_W-1:0]                    r_acc_d;
    logic                                           r_acc_fin;

    // divider chain
    logic [rgbg_pkg::QUO_W:0]        ch_valid;
    rgbg_pkg::t_div_data             ch_data [rgbg_pkg::QUO_W+1];
    logic                            ch_en;
    logic                            out_load;
    logic                            r_out_valid;
    rgbg_pkg::t_out                  r_out_data;

    function automatic logic [1:0] abs_off(input logic [D_W-1:0] k);
        logic [1:0] a;
        if (int'(k) >= RADIUS) begin
            a = 2'(int'(k) - RADIUS);
        end else begin
            a = 2'(RADIUS - int'(k));
        end
        return a;
    endfunction

    // -----------------------------------------------------------------------
    // configuration registers
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= rgbg_pkg::RST_WIDTH;
            r_cfg_height <= rgbg_pkg::RST_HEIGHT;
            r_wgt[0]     <= rgbg_pkg::RST_WGT0;
            r_wgt[1]     <= rgbg_pkg::RST_WGT1;
            r_wgt[2]     <= rgbg_pkg::RST_WGT2;
            r_wgt[3]     <= rgbg_pkg::RST_WGT3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbg_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_wdata;
                rgbg_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_wdata;
                rgbg_pkg::CFG_WGT_CENTER:   r_wgt[0] <= i_cfg_wdata[rgbg_pkg::WGT_W-1:0];
                rgbg_pkg::CFG_WGT_ONE:      r_wgt[1] <= i_cfg_wdata[rgbg_pkg::WGT_W-1:0];
                rgbg_pkg::CFG_WGT_TWO:      r_wgt[2] <= i_cfg_wdata[rgbg_pkg::WGT_W-1:0];
                rgbg_pkg::CFG_WGT_THREE:    r_wgt[3] <= i_cfg_wdata[rgbg_pkg::WGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = W_W'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = H_W'(1);
        end else if (32'(r_cfg_height) > 32'(MAX_HEIGHT)) begin
            h_eff = H_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_W'(r_cfg_height);
        end
    end

    // -----------------------------------------------------------------------
    // position decode
    // -----------------------------------------------------------------------
    always_comb begin
        in_acc     = i_in_valid && !o_in_stall;
        off_c      = P_W'(RADIUS) * P_W'(w_eff) + P_W'(RADIUS);
        last_c     = r_total - P_W'(1) + off_c;
        restart    = (r_p > last_c);
        peff       = restart ? '0 : r_p;
        store      = (peff < r_total);
        has_out    = (peff >= off_c) && ((peff - off_c) < r_total);
        cp         = peff - off_c;
        go         = !(store && !r_real);
        div_start  = (r_state == S_CHK) && go;
        ncol       = (rgbg_pkg::ROW_CNT_W+1)'(r_col) + (rgbg_pkg::ROW_CNT_W+1)'(1);
        ram_we     = (r_state == S_MOD) && col_done && r_store;
    end

    // store address: position modulo the store depth by reciprocal multiply;
    // the estimate is at most one short, so one compare and subtract finishes it
    always_comb begin
        mq_prod = (P_W+RQ_W)'(peff) * (P_W+RQ_W)'(RECIP);
        if (r_mr >= (MD_W+1)'(DEPTH)) begin
            mod_rem = MD_W'(r_mr - (MD_W+1)'(DEPTH));
        end else begin
            mod_rem = r_mr[MD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mq <= mq_prod[P_W+RQ_W-1:P_W];
        r_mr <= (MD_W+1)'(peff - P_W'(r_mq) * P_W'(DEPTH));
    end

    rgbg_idiv #(.NUM_W(P_W), .DEN_W(W_W)) u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (cp),
        .i_den   (w_eff),
        .o_done  (col_done),
        .o_quo   (col_quo),
        .o_rem   (col_rem)
    );

    // -----------------------------------------------------------------------
    // window address walk
    // -----------------------------------------------------------------------
    always_comb begin
        span_c = MD_W'(2 * RADIUS) * MD_W'(w_eff) + MD_W'(2 * RADIUS);
        if (mod_rem >= span_c) begin
            start_addr = (MD_W+1)'(mod_rem - span_c);
        end else begin
            start_addr = (MD_W+1)'(mod_rem) + (MD_W+1)'(DEPTH) - (MD_W+1)'(span_c);
        end
        step_a = (MD_W+1)'(r_rdaddr) + (MD_W+1)'(1);
        if (step_a == (MD_W+1)'(DEPTH)) begin
            step_a = '0;
        end
        // next row: forward one width, back over the span
        jump_a = (MD_W+1)'(r_rdaddr) + (MD_W+1)'(w_eff);
        if (jump_a >= (MD_W+1)'(DEPTH)) begin
            jump_a = jump_a - (MD_W+1)'(DEPTH);
        end
        if (jump_a >= (MD_W+1)'(2 * RADIUS)) begin
            jump_b = jump_a - (MD_W+1)'(2 * RADIUS);
        end else begin
            jump_b = jump_a + (MD_W+1)'(DEPTH) - (MD_W+1)'(2 * RADIUS);
        end
        row_end   = (r_dx == D_W'(2 * RADIUS));
        at_end    = row_end && (r_dy == D_W'(2 * RADIUS));
        next_addr = row_end ? AW'(jump_b) : AW'(step_a);
        inb = !r_rr[RC_W-1] && (r_rr[RC_W-2:0] < (RC_W-1)'(h_eff))
            && !r_cc2[RC_W-1] && (r_cc2[RC_W-2:0] < (RC_W-1)'(w_eff));
        wy = r_wgt[abs_off(r_dy)];
        wx = r_wgt[abs_off(r_dx)];
    end

    // -----------------------------------------------------------------------
    // sequencer
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (restart) begin
                        r_row <= '0;
                        r_col <= '0;
                    end
                    // drop a drain item inside the frame
                    r_state <= go ? S_MOD : S_IDLE;
                end
                S_MOD: begin
                    if (col_done) begin
                        if (r_frame_done) begin
                            r_row <= '0;
                            r_col <= '0;
                        end else if (ncol >= (rgbg_pkg::ROW_CNT_W+1)'(w_eff)) begin
                            r_col <= '0;
                            r_row <= r_row + rgbg_pkg::ROW_CNT_W'(1);
                        end else begin
                            r_col <= ncol[rgbg_pkg::COL_CNT_W-1:0];
                        end
                        r_state <= r_has_out ? S_RUN : S_IDLE;
                    end
                end
                S_RUN: begin
                    if (at_end) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_real <= !i_in_data.req_type;
            r_pix  <= {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
        end
        if (r_state == S_POS) begin
            r_p     <= P_W'(r_row) * P_W'(w_eff) + P_W'(r_col);
            r_total <= P_W'(w_eff) * P_W'(h_eff);
        end
        if (r_state == S_CHK) begin
            r_store      <= store;
            r_has_out    <= has_out;
            r_frame_done <= has_out && (cp == r_total - P_W'(1));
        end
        if ((r_state == S_MOD) && col_done) begin
            r_rdaddr   <= AW'(start_addr);
            r_dy       <= '0;
            r_dx       <= '0;
            r_rr       <= RC_W'(col_quo) - RC_W'(RADIUS);
            r_cc0      <= RC_W'(col_rem) - RC_W'(RADIUS);
            r_cc2      <= RC_W'(col_rem) - RC_W'(RADIUS);
            r_meta_row <= rgbg_pkg::POS_OUT_W'(col_quo);
            r_meta_col <= rgbg_pkg::POS_OUT_W'(col_rem);
        end else if (r_state == S_RUN) begin
            r_rdaddr <= next_addr;
            if (row_end) begin
                r_dx  <= '0;
                r_dy  <= r_dy + D_W'(1);
                r_rr  <= r_rr + RC_W'(1);
                r_cc2 <= r_cc0;
            end else begin
                r_dx  <= r_dx + D_W'(1);
                r_cc2 <= r_cc2 + RC_W'(1);
            end
        end
    end

    rgbg_ram #(.WIDTH(PIX3), .DEPTH(DEPTH)) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (mod_rem[AW-1:0]),
        .i_wdata (r_pix),
        .i_raddr (r_rdaddr),
        .o_rdata (ram_rdata)
    );

    // -----------------------------------------------------------------------
    // weight, multiply, accumulate
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc_fin  <= 1'b0;
        end else begin
            r_s1_valid <= (r_state == S_RUN);
            r_s2_valid <= r_s1_valid;
            r_acc_fin  <= r_s2_valid && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= at_end;
        r_s1_inb  <= inb;
        r_s1_cw   <= rgbg_pkg::CW_W'(wy) * rgbg_pkg::CW_W'(wx);
        r_s2_last <= r_s1_last;
        r_s2_d    <= r_s1_inb ? r_s1_cw : '0;
        for (int c = 0; c < rgbg_pkg::N_CH; c++) begin
            r_s2_prod[c] <= r_s1_inb
                ? rgbg_pkg::PROD_W'(r_s1_cw)
                  * rgbg_pkg::PROD_W'(ram_rdata[(2 - c) * rgbg_pkg::PIX_W +: rgbg_pkg::PIX_W])
                : '0;
        end
        if ((r_state == S_MOD) && col_done) begin
            r_acc   <= '0;
            r_acc_d <= '0;
        end else if (r_s2_valid) begin
            for (int c = 0; c < rgbg_pkg::N_CH; c++) begin
                r_acc[c] <= r_acc[c] + rgbg_pkg::ACC_W'(r_s2_prod[c]);
            end
            r_acc_d <= r_acc_d + rgbg_pkg::DSUM_W'(r_s2_d);
        end
    end

    // -----------------------------------------------------------------------
    // rounding divider chain: floor((2S + D) / 2D), one bit per cell
    // -----------------------------------------------------------------------
    always_comb begin
        ch_valid[0] = r_acc_fin;
        for (int c = 0; c < rgbg_pkg::N_CH; c++) begin
            ch_data[0].rem[c] = {r_acc[c], 1'b0} + rgbg_pkg::NUM_W'(r_acc_d);
        end
        ch_data[0].dd   = {r_acc_d, 1'b0};
        ch_data[0].quo  = '0;
        ch_data[0].zero = (r_acc_d == '0);
        ch_data[0].row  = r_meta_row;
        ch_data[0].col  = r_meta_col;
        ch_data[0].done = r_frame_done;
        // hold the chain while its result cannot move to the output
        ch_en    = !(ch_valid[rgbg_pkg::QUO_W] && r_out_valid && i_out_stall);
        out_load = ch_valid[rgbg_pkg::QUO_W] && (!r_out_valid || !i_out_stall);
    end

    for (genvar k = 0; k < rgbg_pkg::QUO_W; k++) begin : g_cell
        rgbg_div_cell #(.SHIFT(rgbg_pkg::QUO_W - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (ch_en),
            .i_valid (ch_valid[k]),
            .i_data  (ch_data[k]),
            .o_valid (ch_valid[k+1]),
            .o_data  (ch_data[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.out_red    <= ch_data[rgbg_pkg::QUO_W].zero
                                     ? '0 : ch_data[rgbg_pkg::QUO_W].quo[0];
            r_out_data.out_green  <= ch_data[rgbg_pkg::QUO_W].zero
                                     ? '0 : ch_data[rgbg_pkg::QUO_W].quo[1];
            r_out_data.out_blue   <= ch_data[rgbg_pkg::QUO_W].zero
                                     ? '0 : ch_data[rgbg_pkg::QUO_W].quo[2];
            r_out_data.out_row    <= ch_data[rgbg_pkg::QUO_W].row;
            r_out_data.out_col    <= ch_data[rgbg_pkg::QUO_W].col;
            r_out_data.frame_done <= ch_data[rgbg_pkg::QUO_W].done;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
    `RGBG_ASSERT_NXT(a_accept_starts, in_acc, r_state == S_POS, "accepted item did not start")
    `RGBG_ASSERT_IMP(a_one_in_chain, 1'b1, $onehot0(ch_valid[rgbg_pkg::QUO_W:1]), "two items in divider chain")
    `RGBG_ASSERT_NXT(a_result_held, ch_valid[rgbg_pkg::QUO_W] && !out_load, ch_valid[rgbg_pkg::QUO_W] && $stable(ch_data[rgbg_pkg::QUO_W]), "blocked result lost")
    `RGBG_ASSERT_IMP(a_store_addr, (r_state == S_MOD) && col_done, mod_rem < MD_W'(DEPTH), "store address out of range")

endmodule

### sv/rgbg_ram.sv
// ---------------------------------------------------------------------------
// rgbg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rgbg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 14336
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rgbg_idiv.sv
// ---------------------------------------------------------------------------
// rgbg_idiv
// Restoring integer divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rgbg_idiv #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   sh;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        sh    = {r_rem, r_num[NUM_W-1]};
        fits  = (sh >= {1'b0, r_den});
        n_rem = fits ? DEN_W'(sh - {1'b0, r_den}) : sh[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
                r_num <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                r_num <= {r_num[NUM_W-2:0], fits};
                r_rem <= n_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

### sv/rgbg_div_cell.sv
// ---------------------------------------------------------------------------
// rgbg_div_cell
// One cell of the rounding divider chain: resolves one quotient bit.
// ---------------------------------------------------------------------------
module rgbg_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  rgbg_pkg::t_div_data i_data,
    output logic                o_valid,
    output rgbg_pkg::t_div_data o_data
);

    logic                       r_valid;
    rgbg_pkg::t_div_data        r_data;
    rgbg_pkg::t_div_data        n_data;
    logic [rgbg_pkg::NUM_W-1:0] ddsh;

    always_comb begin
        ddsh   = rgbg_pkg::NUM_W'(i_data.dd) << SHIFT;
        n_data = i_data;
        for (int c = 0; c < rgbg_pkg::N_CH; c++) begin
            if (i_data.rem[c] >= ddsh) begin
                n_data.rem[c]        = i_data.rem[c] - ddsh;
                n_data.quo[c][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### bench/rgb_gaussian_blur_edge_normalized_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_gaussian_blur_edge_normalized_tb
// Streams frames of RGB pixels, most of them whole, and drain items through the blur block.
// Each output pixel is checked against an in-bench window predictor.
// Sizes and weights change between frames, and both ports idle at random.
// ---------------------------------------------------------------------------
module rgb_gaussian_blur_edge_normalized_tb;

    localparam int RAD        = 3;
    localparam int LIM_W      = 2048;
    localparam int LIM_H      = 2048;
    localparam int HIST_DEPTH = (2 * RAD + 1) * LIM_W;
    localparam int WDOG_LIMIT = 6000;
    localparam int SETTLE     = 150;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [rgbg_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [rgbg_pkg::CFG_W-1:0]     i_cfg_wdata;
    logic                           i_in_valid;
    rgbg_pkg::t_in                  i_in_data;
    logic                           o_in_stall;
    logic                           o_out_valid;
    rgbg_pkg::t_out                 o_out_data;
    logic                           i_out_stall;

    rgb_gaussian_blur_edge_normalized dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // predictor state
    logic [23:0]                pix_hist [HIST_DEPTH];
    logic [rgbg_pkg::CFG_W-1:0] cfg_width;
    logic [rgbg_pkg::CFG_W-1:0] cfg_height;
    logic [rgbg_pkg::WGT_W-1:0] wgt [4];
    int unsigned                pos_row;
    int unsigned                pos_col;

    rgbg_pkg::t_out       blur_expected [$];
    int                   err_count;
    int                   items_sent;
    bit                   hold_req;
    bit                   done_flag;
    int                   idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(logic [rgbg_pkg::CFG_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic longint unsigned div_round(longint unsigned s, longint unsigned d);
        if (d == 0) return 0;
        return (2 * s + d) / (2 * d);
    endfunction

    // advance the blur model by one item (a drain item inside the frame is dropped); returns 1 when a pixel is produced
    function automatic bit blur_predict(rgbg_pkg::t_in item, output rgbg_pkg::t_out res);
        int unsigned w, h, total, off, last, p, cp;
        int cr, cc, rr, c2;
        longint unsigned sr, sg, sb, ds, cw;
        logic [23:0] px;
        bit done;
        bit got;
        w     = clamp_dim(cfg_width, LIM_W);
        h     = clamp_dim(cfg_height, LIM_H);
        total = w * h;
        off   = RAD * w + RAD;
        last  = total - 1 + off;
        p     = pos_row * w + pos_col;
        done  = 1'b0;
        got   = 1'b0;
        res   = '0;
        if (p > last) begin
            pos_row = 0;
            pos_col = 0;
            p = 0;
        end
        if (p < total) begin
            if (item.req_type) return 1'b0;
            pix_hist[p % HIST_DEPTH] = {item.in_red, item.in_green, item.in_blue};
        end
        if (p >= off && p - off < total) begin
            cp = p - off;
            cr = cp / w;
            cc = cp % w;
            sr = 0; sg = 0; sb = 0; ds = 0;
            for (int dy = -RAD; dy <= RAD; dy++) begin
                rr = cr + dy;
                if (rr < 0 || rr >= int'(h)) continue;
                for (int dx = -RAD; dx <= RAD; dx++) begin
                    c2 = cc + dx;
                    if (c2 < 0 || c2 >= int'(w)) continue;
                    cw = longint'(wgt[dy < 0 ? -dy : dy]) * longint'(wgt[dx < 0 ? -dx : dx]);
                    px = pix_hist[(rr * w + c2) % HIST_DEPTH];
                    ds += cw;
                    sr += cw * px[23:16];
                    sg += cw * px[15:8];
                    sb += cw * px[7:0];
                end
            end
            done           = (cp == total - 1);
            res.out_red    = 8'(div_round(sr, ds));
            res.out_green  = 8'(div_round(sg, ds));
            res.out_blue   = 8'(div_round(sb, ds));
            res.out_row    = 11'(cr);
            res.out_col    = 11'(cc);
            res.frame_done = done;
            got            = 1'b1;
        end
        if (done) begin
            pos_row = 0;
            pos_col = 0;
        end else begin
            pos_col++;
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row = (pos_row + 1) & 12'hFFF;
            end
            pos_col &= 11'h7FF;
        end
        return got;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        err_count++;
    endtask

    task automatic send_item(rgbg_pkg::t_in item, bit use_gaps);
        rgbg_pkg::t_out res;
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        if (blur_predict(item, res)) blur_expected.push_back(res);
        items_sent++;
        gap = use_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (blur_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rgbg_pkg::CFG_IDX_W-1:0] idx,
                             logic [rgbg_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == rgbg_pkg::CFG_IMAGE_WIDTH)       cfg_width  = val;
        else if (idx == rgbg_pkg::CFG_IMAGE_HEIGHT) cfg_height = val;
        else if (idx == rgbg_pkg::CFG_WGT_CENTER)   wgt[0]     = val[7:0];
        else if (idx == rgbg_pkg::CFG_WGT_ONE)      wgt[1]     = val[7:0];
        else if (idx == rgbg_pkg::CFG_WGT_TWO)      wgt[2]     = val[7:0];
        else if (idx == rgbg_pkg::CFG_WGT_THREE)    wgt[3]     = val[7:0];
    endtask

    task automatic set_frame(logic [rgbg_pkg::CFG_W-1:0] w, logic [rgbg_pkg::CFG_W-1:0] h,
                             logic [7:0] w0, logic [7:0] w1, logic [7:0] w2, logic [7:0] w3);
        wait_idle();
        write_reg(rgbg_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(rgbg_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(rgbg_pkg::CFG_WGT_CENTER, {4'($urandom), w0});
        write_reg(rgbg_pkg::CFG_WGT_ONE, {4'($urandom), w1});
        write_reg(rgbg_pkg::CFG_WGT_TWO, 12'(w2));
        write_reg(rgbg_pkg::CFG_WGT_THREE, 12'(w3));
    endtask

    // pattern 0 random samples, 1 full-scale extremes
    function automatic rgbg_pkg::t_in make_pixel(int pattern, int n);
        rgbg_pkg::t_in it;
        it.req_type = 1'b0;
        if (pattern == 1) begin
            it.in_red   = n[0] ? 8'hFF : 8'h00;
            it.in_green = n[1] ? 8'hFF : 8'h00;
            it.in_blue  = (n % 3 == 0) ? 8'hFF : 8'h00;
        end else begin
            it.in_red   = 8'($urandom);
            it.in_green = 8'($urandom);
            it.in_blue  = 8'($urandom);
        end
        return it;
    endfunction

    // stream one frame, then drain items until the last pixel comes out
    task automatic run_frame(int pattern, int noise_pct, bit use_gaps, bit hold_mid);
        int unsigned w, h, total, off;
        rgbg_pkg::t_in it;
        w     = clamp_dim(cfg_width, LIM_W);
        h     = clamp_dim(cfg_height, LIM_H);
        total = w * h;
        off   = RAD * w + RAD;
        for (int n = 0; n < total; n++) begin
            if (hold_mid && n == total / 2) hold_req = 1'b1;
            if ($urandom_range(0, 99) < noise_pct) begin
                it = make_pixel(0, n);
                it.req_type = 1'b1;
                send_item(it, use_gaps);
            end
            send_item(make_pixel(pattern, n), use_gaps);
        end
        for (int n = 0; n < off; n++) begin
            // a pixel past the frame end acts as a drain item
            if ($urandom_range(0, 99) < noise_pct) it = make_pixel(0, n);
            else begin
                it = make_pixel(0, n);
                it.req_type = 1'b1;
            end
            send_item(it, use_gaps);
        end
    endtask

    task automatic test_single_pixel();
        set_frame(12'd0, 12'd1, 8'd255, 8'd204, 8'd105, 8'd35);
        run_frame(1, 0, 1'b0, 1'b0);
        set_frame(12'd1, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        run_frame(0, 30, 1'b1, 1'b0);
    endtask

    task automatic test_extremes();
        set_frame(12'd4, 12'd3, 8'd255, 8'd255, 8'd255, 8'd255);
        run_frame(1, 25, 1'b1, 1'b0);
        set_frame(12'd3, 12'd2, 8'd1, 8'd0, 8'd255, 8'd0);
        run_frame(1, 0, 1'b1, 1'b0);
    endtask

    task automatic test_zero_weights();
        set_frame(12'd3, 12'd3, 8'd0, 8'd0, 8'd0, 8'd0);
        run_frame(0, 10, 1'b1, 1'b0);
        // only the far ring carries weight: with two rows no cell reaches it, so every output is zero
        set_frame(12'd5, 12'd2, 8'd0, 8'd0, 8'd0, 8'd255);
        run_frame(0, 0, 1'b1, 1'b0);
    endtask

    // tall single column with the height clipped to the row limit; only the
    // top part is streamed, the next size change lands past the frame and
    // restarts the position
    task automatic test_saturated_height();
        set_frame(12'd1, 12'd4095, 8'd255, 8'd204, 8'd105, 8'd35);
        for (int n = 0; n < 150; n++) begin
            send_item(make_pixel(0, n), 1'b0);
        end
    endtask

    task automatic test_backpressure();
        set_frame(12'd9, 12'd6, 8'd200, 8'd150, 8'd90, 8'd20);
        run_frame(0, 5, 1'b0, 1'b1);
    endtask

    task automatic test_random_frames();
        int start;
        start = items_sent;
        while (items_sent - start < 300) begin
            set_frame(12'($urandom_range(1, 12)), 12'($urandom_range(1, 8)),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            run_frame($urandom_range(0, 3) == 0, $urandom_range(0, 12), 1'b1, 1'b0);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int left;
        int hold_left;
        i_out_stall = 1'b0;
        hold_left = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (left > 0) begin
                left--;
                i_out_stall <= 1'b1;
            end else begin
                left = pick_gap();
                i_out_stall <= (left > 0);
                if (left > 0) left--;
            end
        end
    end

    // check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        rgbg_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (blur_expected.size() == 0) begin
                report_mismatch("unexpected pixel row", o_out_data.out_row, -1);
            end else begin
                want = blur_expected.pop_front();
                if (o_out_data.out_red !== want.out_red)
                    report_mismatch("out_red", o_out_data.out_red, want.out_red);
                if (o_out_data.out_green !== want.out_green)
                    report_mismatch("out_green", o_out_data.out_green, want.out_green);
                if (o_out_data.out_blue !== want.out_blue)
                    report_mismatch("out_blue", o_out_data.out_blue, want.out_blue);
                if (o_out_data.out_row !== want.out_row)
                    report_mismatch("out_row", o_out_data.out_row, want.out_row);
                if (o_out_data.out_col !== want.out_col)
                    report_mismatch("out_col", o_out_data.out_col, want.out_col);
                if (o_out_data.frame_done !== want.frame_done)
                    report_mismatch("frame_done", o_out_data.frame_done, want.frame_done);
            end
        end
    end

    // watchdog: cycles without any accepted item on either port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !done_flag) begin
            $display("rgb_gaussian_blur_edge_normalized_tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = rgbg_pkg::CFG_IMAGE_WIDTH;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        err_count   = 0;
        items_sent  = 0;
        hold_req    = 1'b0;
        done_flag   = 1'b0;
        idle_cycles = 0;
        cfg_width   = rgbg_pkg::RST_WIDTH;
        cfg_height  = rgbg_pkg::RST_HEIGHT;
        wgt[0] = rgbg_pkg::RST_WGT0;
        wgt[1] = rgbg_pkg::RST_WGT1;
        wgt[2] = rgbg_pkg::RST_WGT2;
        wgt[3] = rgbg_pkg::RST_WGT3;
        pos_row = 0;
        pos_col = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_pixel();
        test_extremes();
        test_zero_weights();
        test_backpressure();
        test_saturated_height();
        test_random_frames();

        wait_idle();
        done_flag = 1'b1;
        if (err_count == 0)
            $display("rgb_gaussian_blur_edge_normalized_tb: done, clean");
        else
            $display("rgb_gaussian_blur_edge_normalized_tb: done, errors");
        $finish;
    end

endmodule
